FILE: design/teleop_velocity_motion_scaler_defines.svh
// Assertion macros for the teleop velocity motion scaler.
`ifndef TELEOP_VELOCITY_MOTION_SCALER_DEFINES_SVH
`define TELEOP_VELOCITY_MOTION_SCALER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TVMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define TVMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tvms_pkg.sv
// Types and constants of the teleop velocity motion scaler.
`default_nettype none
package tvms_pkg;

    typedef struct packed {
        logic               enabled;
        logic signed [31:0] arm_a_x;
        logic signed [31:0] arm_a_y;
        logic signed [31:0] arm_a_z;
        logic        [31:0] arm_a_time;
        logic signed [31:0] arm_b_x;
        logic signed [31:0] arm_b_y;
        logic signed [31:0] arm_b_z;
        logic        [31:0] arm_b_time;
    } in_item_t;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] target_a_x;
        logic signed [31:0] target_a_y;
        logic signed [31:0] target_a_z;
        logic signed [31:0] target_b_x;
        logic signed [31:0] target_b_y;
        logic signed [31:0] target_b_z;
    } out_item_t;

    localparam logic [2:0] ACT_WARMUP   = 3'd0;
    localparam logic [2:0] ACT_SCALED   = 3'd1;
    localparam logic [2:0] ACT_JUMP     = 3'd2;
    localparam logic [2:0] ACT_SAME     = 3'd3;
    localparam logic [2:0] ACT_DISABLED = 3'd4;

    localparam logic [2:0] CFG_WLIN = 3'd0;
    localparam logic [2:0] CFG_WSQ  = 3'd1;
    localparam logic [2:0] CFG_CAP  = 3'd2;
    localparam logic [2:0] CFG_JUMP = 3'd3;
    localparam logic [2:0] CFG_WARM = 3'd4;

    localparam int          CFG_DATA_W  = 48;
    localparam logic [23:0] WLIN_RESET  = 24'd1311;
    localparam logic [23:0] WSQ_RESET   = 24'd0;
    localparam logic [22:0] CAP_RESET   = 23'd65536;
    localparam logic [47:0] JUMP_RESET  = 48'd4398047;
    localparam logic [7:0]  WARM_RESET  = 8'd10;

    localparam logic [24:0] JUMP_CLAMP  = 25'h1000000;
    localparam logic [13:0] DT_SCALE    = 14'd15625;
    localparam logic [5:0]  DIV_LAST    = 6'd61;
    localparam logic [2:0]  AXIS_LAST   = 3'd5;
    localparam logic [2:0]  AXIS_B0     = 3'd3;

endpackage
`default_nettype wire

FILE: design/tvms_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface tvms_in_if;
    import tvms_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tvms_out_if;
    import tvms_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/teleop_velocity_motion_scaler.sv
// Teleop velocity motion scaler: sequencer around a shared restoring divider.
//
// in_ch carries one request per sample: enable flag, xyz position and timestamp
// of both master arms. out_ch returns one result per request: action code and
// the six commanded target positions. Registers are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the block is idle, the block does not enforce it.
// Disabled and warm-up requests go from idle straight to output. Scaled requests
// run the jump sum over six axes and the check, then per axis prep, scale, the
// 62-step restoring divide that forms the scaled squared displacement over dt,
// square, sum and update. Jump-rejected and same-stamp requests end at the check.
// One request is worked on at a time; in_ch.ready is high only while idle.
// Results sit in an output register, so a new request is accepted while an
// earlier result waits; the sequencer holds a finished result until that
// register is free. When the receiver stalls, out_ch.payload holds.
// Reset clears the sequencer, the previous positions, stamps and targets, and
// restarts warm-up; registers take their default values.
`default_nettype none
`include "teleop_velocity_motion_scaler_defines.svh"
module teleop_velocity_motion_scaler (
    input  wire                              clk,
    input  wire                              rst_n,
    tvms_in_if.sink                          in_ch,
    tvms_out_if.source                       out_ch,
    input  wire                              cfg_write,
    input  wire [2:0]                        cfg_index,
    input  wire [tvms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tvms_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_JUMP  = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_SCALE = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_SQ    = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic signed [23:0] wlin_reg;
    logic signed [23:0] wsq_reg;
    logic        [22:0] cap_reg;
    logic        [47:0] jump_reg;
    logic        [7:0]  warm_reg;

    logic signed [31:0] pos_reg [6];
    logic signed [31:0] prev_reg [6];
    logic signed [31:0] tgt_reg [6];
    logic        [31:0] tin_reg [2];
    logic        [31:0] ptime_reg [2];
    logic        [7:0]  wcnt_reg;
    logic               in_warm_reg;
    logic        [2:0]  action_reg;
    logic        [2:0]  axis_reg;

    logic        [49:0] suma_reg;
    logic        [49:0] sumb_reg;
    logic        [49:0] magsq_reg;
    logic signed [25:0] dc_reg;
    logic signed [49:0] linp_reg;
    logic signed [49:0] capp_reg;
    logic        [61:0] quo_reg;
    logic        [32:0] rem_reg;
    logic        [31:0] dvs_reg;
    logic        [5:0]  dcnt_reg;
    logic        [55:0] phi_reg;
    logic        [39:0] plo_reg;
    logic signed [33:0] lin_reg;
    logic signed [33:0] capv_reg;
    logic signed [57:0] tot_reg;

    logic               out_valid_reg;
    out_item_t          out_reg;

    // current axis arithmetic
    logic signed [32:0] d_cur;
    logic        [32:0] absd;
    logic        [24:0] mag;
    logic signed [25:0] dc;
    logic        [49:0] mag_sq;
    logic        [31:0] dt_cur;
    logic        [32:0] div_shift;
    logic               div_ge;
    logic        [23:0] w2m;
    logic signed [49:0] lin_adj;
    logic signed [49:0] cap_adj;
    logic        [55:0] sqm;
    logic signed [57:0] sq_s;
    logic        [57:0] abs_tot;
    logic        [33:0] abs_cap;
    logic signed [33:0] step;
    logic signed [34:0] tsum;
    logic signed [31:0] tsat;
    logic        [8:0]  wnext;
    logic               same_stamp;
    logic               jump_hit;
    logic               out_free;
    logic signed [31:0] in_pos [6];

    assign in_pos[0] = in_ch.payload.arm_a_x;
    assign in_pos[1] = in_ch.payload.arm_a_y;
    assign in_pos[2] = in_ch.payload.arm_a_z;
    assign in_pos[3] = in_ch.payload.arm_b_x;
    assign in_pos[4] = in_ch.payload.arm_b_y;
    assign in_pos[5] = in_ch.payload.arm_b_z;

    always_comb
    begin
        d_cur  = {pos_reg[axis_reg][31], pos_reg[axis_reg]}
               - {prev_reg[axis_reg][31], prev_reg[axis_reg]};
        absd   = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
        mag    = (absd > {8'd0, JUMP_CLAMP}) ? JUMP_CLAMP : absd[24:0];
        dc     = d_cur[32] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        mag_sq = {25'd0, mag} * {25'd0, mag};
        dt_cur = (axis_reg < AXIS_B0) ? (tin_reg[0] - ptime_reg[0])
                                      : (tin_reg[1] - ptime_reg[1]);
        div_shift = {rem_reg[31:0], quo_reg[61]};
        div_ge    = div_shift >= {1'b0, dvs_reg};
        w2m     = wsq_reg[23] ? 24'(-wsq_reg) : 24'(wsq_reg);
        lin_adj = linp_reg + (linp_reg[49] ? 50'sd65535 : 50'sd0);
        cap_adj = capp_reg + (capp_reg[49] ? 50'sd65535 : 50'sd0);
        sqm     = phi_reg + {32'd0, plo_reg[39:16]};
        sq_s    = signed'({2'b00, sqm});
        abs_tot = tot_reg[57] ? 58'(-tot_reg) : 58'(tot_reg);
        abs_cap = capv_reg[33] ? 34'(-capv_reg) : 34'(capv_reg);
        step    = (abs_tot < {24'd0, abs_cap}) ? tot_reg[33:0] : capv_reg;
        tsum    = 35'(tgt_reg[axis_reg]) + 35'(step);
        if (tsum > 35'sh07FFFFFFF)
            tsat = 32'sh7FFFFFFF;
        else if (tsum < -35'sh080000000)
            tsat = 32'sh80000000;
        else
            tsat = tsum[31:0];
        wnext      = {1'b0, wcnt_reg} + 9'd1;
        same_stamp = (tin_reg[0] == ptime_reg[0]) || (tin_reg[1] == ptime_reg[1]);
        jump_hit   = (suma_reg > {2'b00, jump_reg}) || (sumb_reg > {2'b00, jump_reg});
        out_free   = !out_valid_reg || out_ch.ready;
    end

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlin_reg <= WLIN_RESET;
            wsq_reg  <= WSQ_RESET;
            cap_reg  <= CAP_RESET;
            jump_reg <= JUMP_RESET;
            warm_reg <= WARM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WLIN: wlin_reg <= cfg_data[23:0];
                CFG_WSQ:  wsq_reg  <= cfg_data[23:0];
                CFG_CAP:  cap_reg  <= cfg_data[22:0];
                CFG_JUMP: jump_reg <= cfg_data[47:0];
                CFG_WARM: warm_reg <= cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    for (int i = 0; i < 6; i++)
                        pos_reg[i] <= in_pos[i];
                    tin_reg[0] <= in_ch.payload.arm_a_time;
                    tin_reg[1] <= in_ch.payload.arm_b_time;
                end
            end
            S_PREP:
            begin
                magsq_reg <= mag_sq;
                dc_reg    <= dc;
                dvs_reg   <= (dt_cur == 32'd0) ? 32'd1 : dt_cur;
            end
            S_SCALE:
            begin
                quo_reg  <= 62'(magsq_reg * {48'd0, DT_SCALE});
                rem_reg  <= '0;
                linp_reg <= 50'(wlin_reg) * 50'(dc_reg);
                capp_reg <= 50'(signed'({1'b0, cap_reg})) * 50'(dc_reg);
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? (div_shift - {1'b0, dvs_reg}) : div_shift;
                quo_reg <= {quo_reg[60:0], div_ge};
            end
            S_SQ:
            begin
                phi_reg  <= {32'd0, w2m} * {24'd0, quo_reg[61:30]};
                plo_reg  <= {16'd0, w2m} * {24'd0, quo_reg[29:14]};
                lin_reg  <= lin_adj[49:16];
                capv_reg <= cap_adj[49:16];
            end
            S_SUM:
            begin
                tot_reg <= (((dc_reg < 0) != wsq_reg[23]) ? -sq_s : sq_s)
                         + 58'(lin_reg);
            end
            default: ;
        endcase
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < 6; i++)
            begin
                prev_reg[i] <= '0;
                tgt_reg[i]  <= '0;
            end
            ptime_reg[0]  <= '0;
            ptime_reg[1]  <= '0;
            wcnt_reg      <= '0;
            in_warm_reg   <= 1'b1;
            action_reg    <= ACT_DISABLED;
            axis_reg      <= '0;
            suma_reg      <= '0;
            sumb_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // drop the result once taken, unless a new one is loaded now
            if (out_valid_reg && out_ch.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    axis_reg <= '0;
                    suma_reg <= '0;
                    sumb_reg <= '0;
                    if (in_ch.valid)
                    begin
                        if (!in_ch.payload.enabled)
                        begin
                            action_reg <= ACT_DISABLED;
                            state_reg  <= S_OUT;
                        end
                        else if (in_warm_reg)
                        begin
                            for (int i = 0; i < 6; i++)
                            begin
                                prev_reg[i] <= in_pos[i];
                                tgt_reg[i]  <= in_pos[i];
                            end
                            ptime_reg[0] <= in_ch.payload.arm_a_time;
                            ptime_reg[1] <= in_ch.payload.arm_b_time;
                            if (wnext > {1'b0, warm_reg})
                                in_warm_reg <= 1'b0;
                            wcnt_reg   <= wnext[8] ? 8'hFF : wnext[7:0];
                            action_reg <= ACT_WARMUP;
                            state_reg  <= S_OUT;
                        end
                        else
                            state_reg <= S_JUMP;
                    end
                end
                S_JUMP:
                begin
                    if (axis_reg < AXIS_B0)
                        suma_reg <= suma_reg + mag_sq;
                    else
                        sumb_reg <= sumb_reg + mag_sq;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_reg  <= '0;
                        state_reg <= S_CHECK;
                    end
                    else
                        axis_reg <= axis_reg + 3'd1;
                end
                S_CHECK:
                begin
                    if (jump_hit)
                    begin
                        for (int i = 0; i < 6; i++)
                            prev_reg[i] <= pos_reg[i];
                        ptime_reg[0] <= tin_reg[0];
                        ptime_reg[1] <= tin_reg[1];
                        action_reg   <= ACT_JUMP;
                        state_reg    <= S_OUT;
                    end
                    else if (same_stamp)
                    begin
                        action_reg <= ACT_SAME;
                        state_reg  <= S_OUT;
                    end
                    else
                        state_reg <= S_PREP;
                end
                S_PREP:  state_reg <= S_SCALE;
                S_SCALE:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == DIV_LAST)
                        state_reg <= S_SQ;
                end
                S_SQ:    state_reg <= S_SUM;
                S_SUM:   state_reg <= S_UPD;
                S_UPD:
                begin
                    tgt_reg[axis_reg] <= tsat;
                    if (axis_reg == AXIS_LAST)
                    begin
                        // previous samples advance only once every axis is done
                        for (int i = 0; i < 6; i++)
                            prev_reg[i] <= pos_reg[i];
                        ptime_reg[0] <= tin_reg[0];
                        ptime_reg[1] <= tin_reg[1];
                        action_reg   <= ACT_SCALED;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 3'd1;
                        state_reg <= S_PREP;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg.action     <= action_reg;
                        out_reg.target_a_x <= tgt_reg[0];
                        out_reg.target_a_y <= tgt_reg[1];
                        out_reg.target_a_z <= tgt_reg[2];
                        out_reg.target_b_x <= tgt_reg[3];
                        out_reg.target_b_y <= tgt_reg[4];
                        out_reg.target_b_z <= tgt_reg[5];
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                        out_valid_reg <= out_valid_reg;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TVMS_ASSERT_NEXT(a_disabled_out, in_ch.valid && in_ch.ready && !in_ch.payload.enabled, state_reg == S_OUT, "disabled request did not go straight to output")
    `TVMS_ASSERT_NOW(a_warm_end, $fell(in_warm_reg), ({1'b0, wcnt_reg} > {1'b0, warm_reg}) || (wcnt_reg == 8'hFF), "warm-up ended before count passed limit")
    `TVMS_ASSERT_NOW(a_div_axis, state_reg == S_DIV, axis_reg <= AXIS_LAST && dvs_reg != 32'd0, "divider running with bad axis or zero divisor")

endmodule
`default_nettype wire
